@@ rtl/bitmap_font_text_renderer_assert.svh @@
// Assertion macros for the bitmap font text renderer.
// Needs clk and rst_n in the scope of use; no other dependencies.
`ifndef BITMAP_FONT_TEXT_RENDERER_ASSERT_SVH
`define BITMAP_FONT_TEXT_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BFTR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap font renderer check failed");

// Next-cycle implication, disabled during reset
`define BFTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap font renderer check failed");

`endif

@@ rtl/bftr_pkg.sv @@
// Shared types and constants for the bitmap font text renderer.
// No dependencies.
package bftr_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CHARS_PER_LINE = 3'd0;
  localparam logic [2:0] REG_GLYPH_WIDTH    = 3'd1;
  localparam logic [2:0] REG_GLYPH_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_FORE_RGB       = 3'd3;
  localparam logic [2:0] REG_BACK_RGB       = 3'd4;
  localparam logic [2:0] REG_BG_TRANSPARENT = 3'd5;

  // Control characters
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  // Limits on the effective glyph size
  localparam logic [3:0] WIDTH_MAX  = 4'd8;
  localparam logic [4:0] HEIGHT_MAX = 5'd16;

  // Reset values of the registers
  localparam logic [7:0]  RST_CHARS_PER_LINE = 8'd80;
  localparam logic [3:0]  RST_GLYPH_WIDTH    = 4'd8;
  localparam logic [4:0]  RST_GLYPH_HEIGHT   = 5'd16;
  localparam logic [23:0] RST_FORE_RGB       = 24'hFFFFFF;
  localparam logic [23:0] RST_BACK_RGB       = 24'h000000;

  // Effective configuration seen by front and back
  typedef struct packed {
    logic [7:0]  chars_per_line;
    logic [3:0]  width;      // saturated at 8
    logic [4:0]  height;     // saturated at 16
    logic [7:0]  width_mask; // bit 7 leftmost
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic        transparent;
  } cfg_t;

  // Command passed from front to back
  typedef struct packed {
    logic        is_load;
    logic [11:0] addr;   // store address for a load, glyph base for a draw
    logic [7:0]  data;   // store byte for a load
    logic [11:0] y_base;
    logic [10:0] x_base;
  } cmd_t;

  // Queue status
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [1:0] count;
  } fifo_stat_t;

endpackage

@@ rtl/bftr_front.sv @@
// Front end: accepts input items, keeps the cursor and issues commands.
// Depends on bftr_pkg.
module bftr_front #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bftr_pkg::cfg_t    cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,
  input  logic              in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output bftr_pkg::cmd_t    q_cmd
);
  import bftr_pkg::*;

  localparam logic [9:0]  COUNT_C = 10'(GLYPH_COUNT);
  localparam logic [11:0] ROWS_C  = 12'(MAX_GLYPH_ROWS);

  logic [7:0]  cursor_col_r, cursor_col_nxt;
  logic [7:0]  cursor_row_r, cursor_row_nxt;
  logic        accept;
  logic        is_load;
  logic [7:0]  code;
  logic [9:0]  code_ext;
  logic [9:0]  code_mod;
  logic [7:0]  row_inc;
  logic [8:0]  col_inc;
  logic [12:0] y_prod;
  logic [11:0] x_prod;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_load   = in_tuser;
  assign code      = in_tdata[7:0];

  // Wrap the code into the glyph set; one subtract suffices for codes below twice GLYPH_COUNT
  assign code_ext = {2'b00, code};
  assign code_mod = (code_ext >= COUNT_C) ? (code_ext - COUNT_C) : code_ext;

  // Cell origin in pixels
  assign y_prod = 13'(cursor_row_r * cfg.height);
  assign x_prod = 12'(cursor_col_r * cfg.width);

  // Build the command
  always_comb begin
    q_cmd.is_load = is_load;
    q_cmd.addr    = is_load ? in_tdata[19:8] : 12'(12'(code_mod) * ROWS_C);
    q_cmd.data    = in_tdata[27:20];
    q_cmd.y_base  = y_prod[11:0];
    q_cmd.x_base  = x_prod[10:0];
  end

  // Push loads and printable characters with a non-empty glyph
  assign q_push = accept && (is_load ||
                  (code != CODE_NEWLINE && code != CODE_RETURN && cfg.height != 5'd0));

  // Advance the cursor
  assign row_inc = (cursor_row_r == 8'hFF) ? cursor_row_r : cursor_row_r + 8'd1;
  assign col_inc = {1'b0, cursor_col_r} + 9'd1;

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    if (accept && !is_load) begin
      priority if (code == CODE_NEWLINE) begin
        cursor_col_nxt = 8'd0;
        cursor_row_nxt = row_inc;
      end else if (code == CODE_RETURN) begin
        cursor_col_nxt = 8'd0;
      end else if (col_inc >= {1'b0, cfg.chars_per_line}) begin
        cursor_col_nxt = 8'd0;
        cursor_row_nxt = row_inc;
      end else begin
        cursor_col_nxt = col_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= 8'd0;
      cursor_row_r <= 8'd0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

endmodule

@@ rtl/bftr_fifo.sv @@
// Two-entry command queue between front and back.
// Depends on bftr_pkg.
module bftr_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bftr_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output bftr_pkg::cmd_t      pop_cmd,
  output bftr_pkg::fifo_stat_t stat
);
  import bftr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign stat.count = count_r;
  assign stat.push  = push;
  assign stat.pop   = pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/bftr_back.sv @@
// Back end: glyph store, row sequencer and output register.
// Depends on bftr_pkg.
module bftr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bftr_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  bftr_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [87:0]       out_tdata,
  output logic              out_tlast
);
  import bftr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  store [4096];
  logic [7:0]  rdata_r;
  logic [11:0] base_r;
  logic [11:0] y_base_r;
  logic [10:0] x_base_r;
  logic [3:0]  row_r, row_nxt;
  logic        row_last;
  logic        issue;
  logic        adv;
  logic        store_we;
  logic [11:0] raddr;

  // Read stage
  logic        rd_v_r;
  logic [11:0] rd_y_r;
  logic [10:0] rd_x_r;
  logic        rd_last_r;

  // Output register
  logic        out_v_r;
  logic [11:0] out_y_r;
  logic [10:0] out_x_r;
  logic [7:0]  out_fg_mask_r;
  logic [7:0]  out_wr_mask_r;
  logic [23:0] out_fg_r;
  logic [23:0] out_bg_r;
  logic        out_last_r;
  logic [7:0]  fg_mask;

  assign adv      = rd_v_r && (!out_v_r || out_tready);
  assign issue    = (state_r == ST_DRAW) && (!rd_v_r || adv);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign store_we = q_pop && q_cmd.is_load;
  assign row_last = (({1'b0, row_r} + 5'd1) == cfg.height);
  assign raddr    = base_r + {8'd0, row_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && !q_cmd.is_load) begin
          state_nxt = ST_DRAW;
          row_nxt   = 4'd0;
        end
      end
      ST_DRAW: begin
        if (issue) begin
          row_nxt = row_r + 4'd1;
          if (row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= 4'd0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      if (issue) begin
        rd_v_r <= 1'b1;
      end else if (adv) begin
        rd_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Latch the draw command
  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.is_load) begin
      base_r   <= q_cmd.addr;
      y_base_r <= q_cmd.y_base;
      x_base_r <= q_cmd.x_base;
    end
  end

  // Glyph store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[q_cmd.addr] <= q_cmd.data;
    end
    if (issue) begin
      rdata_r <= store[raddr];
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_y_r    <= y_base_r + {8'd0, row_r};
      rd_x_r    <= x_base_r;
      rd_last_r <= row_last;
    end
  end

  // Output register payload
  assign fg_mask = rdata_r & cfg.width_mask;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_y_r       <= rd_y_r;
      out_x_r       <= rd_x_r;
      out_fg_mask_r <= fg_mask;
      out_wr_mask_r <= cfg.transparent ? fg_mask : cfg.width_mask;
      out_fg_r      <= cfg.fore_rgb;
      out_bg_r      <= cfg.back_rgb;
      out_last_r    <= rd_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_bg_r, out_fg_r, out_wr_mask_r, out_fg_mask_r,
                       out_x_r, out_y_r};

endmodule

@@ rtl/bitmap_font_text_renderer.sv @@
// Bitmap font text renderer: a character gives one output transaction per glyph row.
// A draw item passes through the command queue, the sequencer, the store read stage and
// the output register; the back end takes each command from the queue, then does one
// store read per glyph row. Glyph store loads go one per cycle while the queue is not
// full; newline and return only move the cursor. Reset (synchronous, rst_n low) clears
// cursor, registers to their defaults, queue and sequencer; the glyph store is not cleared.
`include "bitmap_font_text_renderer_assert.svh"

module bitmap_font_text_renderer #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], glyph_addr[19:8], glyph_data[27:20]
  input  logic        in_tuser,   // op
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // pixel_y[11:0], pixel_x[22:12], fg_mask[30:23],
                                  // write_mask[38:31], pixel_fg[62:39], pixel_bg[86:63]
  output logic        out_tlast   // last
);
  import bftr_pkg::*;

  logic [7:0]  chars_per_line_r;
  logic [3:0]  glyph_width_r;
  logic [4:0]  glyph_height_r;
  logic [23:0] fore_rgb_r;
  logic [23:0] back_rgb_r;
  logic        bg_transparent_r;
  logic        cfg_we;
  cfg_t        cfg;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;
  logic        q_push;
  logic        q_pop;
  fifo_stat_t  q_stat;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_per_line_r <= RST_CHARS_PER_LINE;
      glyph_width_r    <= RST_GLYPH_WIDTH;
      glyph_height_r   <= RST_GLYPH_HEIGHT;
      fore_rgb_r       <= RST_FORE_RGB;
      back_rgb_r       <= RST_BACK_RGB;
      bg_transparent_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARS_PER_LINE: chars_per_line_r <= cfg_data[7:0];
        REG_GLYPH_WIDTH:    glyph_width_r    <= cfg_data[3:0];
        REG_GLYPH_HEIGHT:   glyph_height_r   <= cfg_data[4:0];
        REG_FORE_RGB:       fore_rgb_r       <= cfg_data;
        REG_BACK_RGB:       back_rgb_r       <= cfg_data;
        REG_BG_TRANSPARENT: bg_transparent_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective configuration: saturate the glyph size, derive the width mask
  always_comb begin
    cfg.chars_per_line = chars_per_line_r;
    cfg.width          = (glyph_width_r > WIDTH_MAX) ? WIDTH_MAX : glyph_width_r;
    cfg.height         = (glyph_height_r > HEIGHT_MAX) ? HEIGHT_MAX : glyph_height_r;
    cfg.width_mask     = ~(8'hFF >> cfg.width);
    cfg.fore_rgb       = fore_rgb_r;
    cfg.back_rgb       = back_rgb_r;
    cfg.transparent    = bg_transparent_r;
  end

  bftr_front #(
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .GLYPH_COUNT    (GLYPH_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  bftr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  bftr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_stat.empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Queue never overruns or underruns, and foreground pixels are always written
  `BFTR_ASSERT_IMPL(a_no_push_full, q_stat.push, !q_stat.full)
  `BFTR_ASSERT_IMPL(a_no_pop_empty, q_stat.pop, !q_stat.empty)
  `BFTR_ASSERT_NEXT(a_count_bound, 1'b1, q_stat.count != 2'd3)
  `BFTR_ASSERT_IMPL(a_fg_in_write, out_tvalid, (out_tdata[30:23] & ~out_tdata[38:31]) == 8'd0)

endmodule
